[src/tlf_pkg.sv]
// Package with the shared types and constants of the three-sensor line follower.
`timescale 1ns / 1ps

package tlf_pkg;

   // Width of the register index on the configuration channel; codes past the last register
   // are ignored.
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LEFT_THRESHOLD   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_THRESHOLD = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RIGHT_THRESHOLD  = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NODE_MARGIN      = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHARP_OFFSET     = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GENTLE_OFFSET    = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASE_SPEED       = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TURN_PULSES      = 4'd7;

   localparam logic [7:0] LEFT_THRESHOLD_RESET   = 8'd15;
   localparam logic [7:0] CENTER_THRESHOLD_RESET = 8'd15;
   localparam logic [7:0] RIGHT_THRESHOLD_RESET  = 8'd15;
   localparam logic [7:0] NODE_MARGIN_RESET      = 8'd40;
   localparam logic [7:0] SHARP_OFFSET_RESET     = 8'd50;
   localparam logic [7:0] GENTLE_OFFSET_RESET    = 8'd30;
   localparam logic [7:0] BASE_SPEED_RESET       = 8'd250;
   localparam logic [7:0] TURN_PULSES_RESET      = 8'd1;

   localparam logic [7:0] BIAS_OFFSET  = 8'd30;
   localparam logic [7:0] SEARCH_SPEED = 8'd200;

   localparam int SEARCH_COUNT_WIDTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      MOTION_STOP       = 2'd0,
      MOTION_FORWARD    = 2'd1,
      MOTION_TURN_LEFT  = 2'd2,
      MOTION_TURN_RIGHT = 2'd3
   } motion_type;

   typedef enum logic [1:0] {
      MOVE_STRAIGHT     = 2'd0,
      MOVE_FAVOUR_LEFT  = 2'd1,
      MOVE_FAVOUR_RIGHT = 2'd2
   } move_type;

   typedef struct packed {
      logic [7:0] left_threshold;
      logic [7:0] center_threshold;
      logic [7:0] right_threshold;
      logic [7:0] node_margin;
      logic [7:0] sharp_offset;
      logic [7:0] gentle_offset;
      logic [7:0] base_speed;
      logic [7:0] turn_pulses;
   } cfg_type;

   typedef struct packed {
      logic [7:0] left_sample;
      logic [7:0] center_sample;
      logic [7:0] right_sample;
   } sample_word_type;

   typedef struct packed {
      logic [7:0] left_speed;
      logic [7:0] right_speed;
      motion_type motion;
      logic [7:0] pulse_count;
      logic       node_reached;
   } result_word_type;

   // Speed reduction that stops at zero.
   function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
      sub_sat = (a > b) ? (a - b) : 8'd0;
   endfunction

endpackage

[src/tlf_if.sv]
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface tlf_sample_if;
   logic                     valid;
   logic                     ready;
   tlf_pkg::sample_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface tlf_result_if;
   logic                     valid;
   logic                     ready;
   tlf_pkg::result_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface tlf_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [tlf_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [7:0]                            data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/tlf_csr.sv]
// Configuration register file of the line follower.
`timescale 1ns / 1ps

module tlf_csr (
   input  logic              clock,
   input  logic              reset,
   tlf_csr_if.sink           csr_bus,
   output tlf_pkg::cfg_type  cfg
);
   import tlf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_LEFT_THRESHOLD:   cfg_in.left_threshold   = csr_bus.data;
            REG_CENTER_THRESHOLD: cfg_in.center_threshold = csr_bus.data;
            REG_RIGHT_THRESHOLD:  cfg_in.right_threshold  = csr_bus.data;
            REG_NODE_MARGIN:      cfg_in.node_margin      = csr_bus.data;
            REG_SHARP_OFFSET:     cfg_in.sharp_offset     = csr_bus.data;
            REG_GENTLE_OFFSET:    cfg_in.gentle_offset    = csr_bus.data;
            REG_BASE_SPEED:       cfg_in.base_speed       = csr_bus.data;
            REG_TURN_PULSES:      cfg_in.turn_pulses      = csr_bus.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_threshold   <= LEFT_THRESHOLD_RESET;
         cfg_ff.center_threshold <= CENTER_THRESHOLD_RESET;
         cfg_ff.right_threshold  <= RIGHT_THRESHOLD_RESET;
         cfg_ff.node_margin      <= NODE_MARGIN_RESET;
         cfg_ff.sharp_offset     <= SHARP_OFFSET_RESET;
         cfg_ff.gentle_offset    <= GENTLE_OFFSET_RESET;
         cfg_ff.base_speed       <= BASE_SPEED_RESET;
         cfg_ff.turn_pulses      <= TURN_PULSES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/tlf_core.sv]
// Steering decision logic and the controller state it keeps between words.
`timescale 1ns / 1ps

module tlf_core #(
   parameter int SEARCH_COUNT_WIDTH = tlf_pkg::SEARCH_COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  tlf_pkg::cfg_type          cfg,
   input  tlf_pkg::sample_word_type  sample,
   output tlf_pkg::result_word_type  result
);
   import tlf_pkg::*;

   localparam int CW = SEARCH_COUNT_WIDTH;

   move_type        last_move_ff, last_move_in;
   logic [CW-1:0]   try_count_ff, try_count_in;
   logic [CW-1:0]   sweep_count_ff, sweep_count_in;
   logic [7:0]      held_left_ff, held_left_in;
   logic [7:0]      held_right_ff, held_right_in;
   motion_type      held_motion_ff, held_motion_in;

   logic            lh, ll, ch, cl, rh, rl;
   logic            is_node;
   logic [8:0]      left_node_level, center_node_level, right_node_level;
   logic [CW-1:0]   sweep_mid, try_mid;
   logic            first_half;

   always_comb begin
      lh = sample.left_sample   > cfg.left_threshold;
      ll = sample.left_sample   < cfg.left_threshold;
      ch = sample.center_sample > cfg.center_threshold;
      cl = sample.center_sample < cfg.center_threshold;
      rh = sample.right_sample  > cfg.right_threshold;
      rl = sample.right_sample  < cfg.right_threshold;

      left_node_level   = {1'b0, cfg.left_threshold}   + {1'b0, cfg.node_margin};
      center_node_level = {1'b0, cfg.center_threshold} + {1'b0, cfg.node_margin};
      right_node_level  = {1'b0, cfg.right_threshold}  + {1'b0, cfg.node_margin};
      is_node = (({1'b0, sample.left_sample} > left_node_level) ||
                 ({1'b0, sample.right_sample} > right_node_level)) &&
                ({1'b0, sample.center_sample} > center_node_level);

      // Search step: a completed sweep starts a longer one.
      if (sweep_count_ff == try_count_ff) begin
         sweep_mid = '0;
         try_mid   = try_count_ff + {{(CW-1){1'b0}}, 1'b1};
      end else begin
         sweep_mid = sweep_count_ff;
         try_mid   = try_count_ff;
      end
      first_half = ~try_count_ff[1];
   end

   always_comb begin
      result.left_speed   = held_left_ff;
      result.right_speed  = held_right_ff;
      result.motion       = held_motion_ff;
      result.pulse_count  = 8'd0;
      result.node_reached = 1'b0;
      last_move_in   = last_move_ff;
      try_count_in   = try_count_ff;
      sweep_count_in = sweep_count_ff;
      held_left_in   = held_left_ff;
      held_right_in  = held_right_ff;
      held_motion_in = held_motion_ff;

      if (ll && cl && rl) begin
         result.left_speed  = SEARCH_SPEED;
         result.right_speed = SEARCH_SPEED;
         if (last_move_ff == MOVE_FAVOUR_LEFT) begin
            result.motion = first_half ? MOTION_TURN_RIGHT : MOTION_TURN_LEFT;
         end else begin
            result.motion = first_half ? MOTION_TURN_LEFT : MOTION_TURN_RIGHT;
         end
         result.pulse_count = cfg.turn_pulses;
         try_count_in   = try_mid;
         sweep_count_in = (sweep_mid < try_mid) ?
                          (sweep_mid + {{(CW-1){1'b0}}, 1'b1}) : sweep_mid;
         held_left_in   = SEARCH_SPEED;
         held_right_in  = SEARCH_SPEED;
         held_motion_in = MOTION_STOP;
      end else if ((ll || lh) && (cl || ch) && (rl || rh) &&
                   !(lh && rh) && !(lh && cl && rh)) begin
         // Every defined tracking pattern: drive forward.
         result.motion = MOTION_FORWARD;
         if (ll && rh) begin
            result.left_speed  = cfg.base_speed;
            result.right_speed = sub_sat(cfg.base_speed,
                                         cl ? cfg.sharp_offset : cfg.gentle_offset);
            last_move_in = MOVE_FAVOUR_LEFT;
         end else if (lh && rl) begin
            result.left_speed  = sub_sat(cfg.base_speed,
                                         cl ? cfg.sharp_offset : cfg.gentle_offset);
            result.right_speed = cfg.base_speed;
            last_move_in = MOVE_FAVOUR_RIGHT;
         end else begin
            result.left_speed  = (last_move_ff == MOVE_FAVOUR_LEFT) ?
                                 sub_sat(cfg.base_speed, BIAS_OFFSET) : cfg.base_speed;
            result.right_speed = (last_move_ff == MOVE_FAVOUR_RIGHT) ?
                                 sub_sat(cfg.base_speed, BIAS_OFFSET) : cfg.base_speed;
            last_move_in = MOVE_STRAIGHT;
         end
         try_count_in   = '0;
         sweep_count_in = '0;
         held_left_in   = result.left_speed;
         held_right_in  = result.right_speed;
         held_motion_in = MOTION_FORWARD;
      end

      if (is_node) begin
         result.left_speed   = 8'd0;
         result.right_speed  = 8'd0;
         result.motion       = MOTION_STOP;
         result.pulse_count  = 8'd0;
         result.node_reached = 1'b1;
         last_move_in   = MOVE_STRAIGHT;
         try_count_in   = '0;
         sweep_count_in = '0;
         held_left_in   = 8'd0;
         held_right_in  = 8'd0;
         held_motion_in = MOTION_STOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_move_ff   <= MOVE_STRAIGHT;
         try_count_ff   <= '0;
         sweep_count_ff <= '0;
         held_left_ff   <= 8'd0;
         held_right_ff  <= 8'd0;
         held_motion_ff <= MOTION_STOP;
      end else if (step) begin
         last_move_ff   <= last_move_in;
         try_count_ff   <= try_count_in;
         sweep_count_ff <= sweep_count_in;
         held_left_ff   <= held_left_in;
         held_right_ff  <= held_right_in;
         held_motion_ff <= held_motion_in;
      end
   end

endmodule

[src/three_sensor_line_follower_top.sv]
// Top level of the three-sensor line follower controller.
`timescale 1ns / 1ps

// The block takes one word of left, centre and right sensor samples on the
// req_bus channel and returns exactly one result word on rsp_bus: the two
// wheel speeds, a motion code, the pulse count of a search turn and a node
// flag. An accepted word is held in an input register; once the output
// register can take it, the threshold compares, the steering choice and
// the state update are worked out and the result is written to the
// output register, which offers the result word on rsp_bus until it is
// taken. A new word is accepted in every cycle while results are being
// taken. While a finished result waits, one more word can still be taken
// into an empty input register; the input stalls only when both registers
// are full and the waiting result is not being taken. The state (last
// correction, search counters and held command) is updated in the same
// cycle that a word moves into the output register, so successive words
// see each other's effects in order. The search counters are
// SEARCH_COUNT_WIDTH bits wide and wrap. The configuration registers are
// written through csr_bus, which is always ready; writes to an index
// beyond the register list are ignored.
// Configuration should only be changed while no word is in flight.

module three_sensor_line_follower_top #(
   parameter int SEARCH_COUNT_WIDTH = tlf_pkg::SEARCH_COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tlf_sample_if.sink   req_bus,
   tlf_result_if.source rsp_bus,
   tlf_csr_if.sink      csr_bus
);
   import tlf_pkg::*;

   cfg_type          cfg;
   sample_word_type  sample_ff;
   logic             sample_valid_ff, sample_valid_in;
   result_word_type  result;
   result_word_type  result_ff;
   logic             result_valid_ff, result_valid_in;
   logic             advance;

   // The output register can take a new word when it is empty or being drained.
   assign advance       = !result_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !sample_valid_ff || advance;

   assign rsp_bus.valid = result_valid_ff;
   assign rsp_bus.word  = result_ff;

   tlf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tlf_core #(
      .SEARCH_COUNT_WIDTH (SEARCH_COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (sample_valid_ff && advance),
      .cfg    (cfg),
      .sample (sample_ff),
      .result (result)
   );

   always_comb begin
      sample_valid_in = sample_valid_ff;
      if (req_bus.ready) begin
         sample_valid_in = req_bus.valid;
      end
      result_valid_in = result_valid_ff;
      if (advance) begin
         result_valid_in = sample_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         sample_valid_ff <= sample_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         sample_ff <= req_bus.word;
      end
      if (advance && sample_valid_ff) begin
         result_ff <= result;
      end
   end

endmodule
